/* hdl/wdwa_pkg.sv */
// shared constants, types and coefficient tables for the windowed decay average
`default_nettype none
package wdwa_pkg;

   localparam int HIST_DEPTH     = 16;
   localparam int MAX_COMPONENTS = 4;
   localparam int SLOT_W         = 4;
   localparam int COMP_W         = 2;
   localparam int ADDR_W         = SLOT_W + COMP_W;
   localparam int MEM_DEPTH      = HIST_DEPTH * MAX_COMPONENTS;
   localparam int VAL_W          = 16;
   localparam int WIN_W          = 5;
   localparam int WGT_W          = 16;
   localparam int RCP_W          = 17;
   localparam int ACC_W          = 36;
   localparam int MULB_W         = RCP_W + 1;
   localparam int PROD_W         = ACC_W + MULB_W;
   localparam int ROUND_SHIFT    = 31;

   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(16);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_DRAIN,
      ST_NORM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              load;
      logic              add_prod;
      logic              sel_norm;
      logic              comp_ok;
      logic [SLOT_W-1:0] age;
      logic [WIN_W-1:0]  n;
   } ctl_type;

   // exp(-0.05*age) in unsigned q1.15
   function automatic logic [WGT_W-1:0] weight_of(input logic [SLOT_W-1:0] age);
      logic [WGT_W-1:0] w;
      unique case (age)
         4'd0:    w = 16'd32768;
         4'd1:    w = 16'd31170;
         4'd2:    w = 16'd29650;
         4'd3:    w = 16'd28204;
         4'd4:    w = 16'd26828;
         4'd5:    w = 16'd25520;
         4'd6:    w = 16'd24275;
         4'd7:    w = 16'd23091;
         4'd8:    w = 16'd21965;
         4'd9:    w = 16'd20894;
         4'd10:   w = 16'd19875;
         4'd11:   w = 16'd18905;
         4'd12:   w = 16'd17983;
         4'd13:   w = 16'd17106;
         4'd14:   w = 16'd16272;
         4'd15:   w = 16'd15479;
         default: w = '0;
      endcase
      return w;
   endfunction

   // reciprocal of the weight total for a window of n vectors, unsigned q1.16
   function automatic logic [RCP_W-1:0] recip_of(input logic [WIN_W-1:0] n);
      logic [RCP_W-1:0] r;
      unique case (n)
         5'd1:    r = 17'd65536;
         5'd2:    r = 17'd33587;
         5'd3:    r = 17'd22946;
         5'd4:    r = 17'd17632;
         5'd5:    r = 17'd14450;
         5'd6:    r = 17'd12332;
         5'd7:    r = 17'd10823;
         5'd8:    r = 17'd9695;
         5'd9:    r = 17'd8820;
         5'd10:   r = 17'd8123;
         5'd11:   r = 17'd7555;
         5'd12:   r = 17'd7084;
         5'd13:   r = 17'd6687;
         5'd14:   r = 17'd6349;
         5'd15:   r = 17'd6058;
         5'd16:   r = 17'd5804;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/windowed_decay_weighted_average_top.sv */
// Windowed decay-weighted average. Each request is one signed q7.8 vector
// component; it is written into the current history slot and answered with
// the exp(-0.05*age) weighted mean over the newest n vectors, where
// n = min(completed vectors + 1, window_length clamped to 1..16). One shared
// multiplier does all the work: it walks the n history entries one per cycle,
// then scales by the reciprocal of the weight total; a new request is only
// accepted once the previous result has gone into the result register. The
// result register lets a new request in while the previous response is still
// waiting. A request marked last component advances the ring slot.
// window_length resets to 16; the user is to write it through csr_wr_en/
// csr_wr_data only while no request is in flight, which the block does not enforce.
`default_nettype none
module windowed_decay_weighted_average_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [wdwa_pkg::WIN_W-1:0]         csr_wr_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [wdwa_pkg::VAL_W-1:0]  req_reward_value,
   input  wire logic [wdwa_pkg::COMP_W-1:0]        req_component,
   input  wire logic                              req_last_component,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [wdwa_pkg::VAL_W-1:0]       rsp_smoothed_value,
   output logic [wdwa_pkg::COMP_W-1:0]             rsp_component_out
);
   import wdwa_pkg::*;

   logic [WIN_W-1:0]  win_len_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]  rsp_value_ff;
   logic [COMP_W-1:0] rsp_comp_ff;

   logic              out_free;
   logic              out_load;
   logic [COMP_W-1:0] comp_out;
   logic              hist_wr_en;
   logic [ADDR_W-1:0] hist_wr_addr;
   logic [ADDR_W-1:0] hist_rd_addr;
   logic [VAL_W-1:0]  hist_rd_data;
   logic [VAL_W-1:0]  result;
   ctl_type           ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= WIN_RESET;
      end else if (csr_wr_en) begin
         win_len_ff <= csr_wr_data;
      end
   end

   wdwa_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_component      (req_component),
      .req_last_component (req_last_component),
      .window_length      (win_len_ff),
      .out_free           (out_free),
      .out_load           (out_load),
      .comp_out           (comp_out),
      .hist_wr_en         (hist_wr_en),
      .hist_wr_addr       (hist_wr_addr),
      .hist_rd_addr       (hist_rd_addr),
      .ctl                (ctl)
   );

   wdwa_hist u_hist (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (req_reward_value),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   wdwa_mac u_mac (
      .clock     (clock),
      .ctl       (ctl),
      .req_value (req_reward_value),
      .rd_data   (hist_rd_data),
      .result    (result)
   );

   // response register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_value_ff <= result;
         rsp_comp_ff  <= comp_out;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smoothed_value = $signed(rsp_value_ff);
   assign rsp_component_out  = rsp_comp_ff;

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("response overwritten while held");

   a_resp_after_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("loaded response not presented");

   a_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      hist_wr_en |-> req_valid && !req_stall)
      else $error("history written without an accepted request");

endmodule
`default_nettype wire

/* hdl/wdwa_hist.sv */
// history memory: one write port, one registered read port
`default_nettype none
module wdwa_hist (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [wdwa_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [wdwa_pkg::VAL_W-1:0]  wr_data,
   input  wire logic [wdwa_pkg::ADDR_W-1:0] rd_addr,
   output logic      [wdwa_pkg::VAL_W-1:0]  rd_data
);
   import wdwa_pkg::*;

   logic [VAL_W-1:0] mem [MEM_DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/wdwa_mac.sv */
// shared multiplier, accumulator, rounding and saturation
`default_nettype none
module wdwa_mac (
   input  wire logic                      clock,
   input  wire wdwa_pkg::ctl_type         ctl,
   input  wire logic [wdwa_pkg::VAL_W-1:0] req_value,
   input  wire logic [wdwa_pkg::VAL_W-1:0] rd_data,
   output logic      [wdwa_pkg::VAL_W-1:0] result
);
   import wdwa_pkg::*;

   localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(1) << (ROUND_SHIFT - 1);
   localparam logic signed [PROD_W-1:0] SAT_MAX  = PROD_W'((2 ** (VAL_W - 1)) - 1);
   localparam logic signed [PROD_W-1:0] SAT_MIN  = -SAT_MAX - PROD_W'(1);

   logic signed [VAL_W-1:0]  sample_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [PROD_W-1:0] mul_ff;
   logic signed [VAL_W-1:0]  operand;
   logic signed [ACC_W-1:0]  mul_a;
   logic signed [MULB_W-1:0] mul_b;
   logic signed [PROD_W-1:0] rnd_sum;
   logic signed [PROD_W-1:0] shifted;
   logic [VAL_W-1:0]         sat_val;

   // operand select for the shared multiplier
   always_comb begin
      operand = (ctl.age == '0) ? sample_ff : $signed(rd_data);
      if (ctl.sel_norm) begin
         mul_a = acc_ff;
         mul_b = $signed({1'b0, recip_of(ctl.n)});
      end else begin
         mul_a = ACC_W'(operand);
         mul_b = $signed({{(MULB_W - WGT_W){1'b0}}, weight_of(ctl.age)});
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = '0;
      end else if (ctl.add_prod) begin
         acc_in = acc_ff + mul_ff[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         sample_ff <= $signed(req_value);
      end
      acc_ff <= acc_in;
      mul_ff <= PROD_W'(mul_a * mul_b);
   end

   // round half up, then clamp to q7.8
   always_comb begin
      rnd_sum = mul_ff + RND_BIAS;
      shifted = rnd_sum >>> ROUND_SHIFT;
      if (shifted > SAT_MAX) begin
         sat_val = SAT_MAX[VAL_W-1:0];
      end else if (shifted < SAT_MIN) begin
         sat_val = SAT_MIN[VAL_W-1:0];
      end else begin
         sat_val = shifted[VAL_W-1:0];
      end
   end

   assign result = ctl.comp_ok ? sat_val : '0;

endmodule
`default_nettype wire

/* hdl/wdwa_seq.sv */
// sequencer: walks the history window, keeps ring slot and fill count
`default_nettype none
module wdwa_seq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [wdwa_pkg::COMP_W-1:0] req_component,
   input  wire logic                       req_last_component,
   input  wire logic [wdwa_pkg::WIN_W-1:0]  window_length,
   input  wire logic                       out_free,
   output logic                            out_load,
   output logic [wdwa_pkg::COMP_W-1:0]      comp_out,
   output logic                            hist_wr_en,
   output logic [wdwa_pkg::ADDR_W-1:0]      hist_wr_addr,
   output logic [wdwa_pkg::ADDR_W-1:0]      hist_rd_addr,
   output wdwa_pkg::ctl_type               ctl
);
   import wdwa_pkg::*;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [WIN_W-1:0]  fill_ff, fill_in;
   logic [SLOT_W-1:0] age_ff, age_in;
   logic [SLOT_W-1:0] nm1_ff, nm1_in;
   logic [WIN_W-1:0]  n_ff, n_in;
   logic [COMP_W-1:0] comp_ff, comp_in;
   logic              last_ff, last_in;
   logic              comp_ok_ff, comp_ok_in;

   logic              accept;
   logic              req_comp_ok;
   logic [WIN_W-1:0]  wl_clamp;
   logic [WIN_W-1:0]  fill_p1;
   logic [WIN_W-1:0]  n_calc;
   logic [SLOT_W-1:0] rd_age;
   logic [COMP_W-1:0] rd_comp;

   assign accept      = req_valid && !req_stall;
   assign req_comp_ok = int'(req_component) < MAX_COMPONENTS;

   // window size for the incoming request
   always_comb begin
      if (window_length == '0) begin
         wl_clamp = WIN_W'(1);
      end else if (window_length > WIN_W'(HIST_DEPTH)) begin
         wl_clamp = WIN_W'(HIST_DEPTH);
      end else begin
         wl_clamp = window_length;
      end
      fill_p1 = fill_ff + WIN_W'(1);
      n_calc  = (fill_p1 < wl_clamp) ? fill_p1 : wl_clamp;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_ACC;
         ST_ACC:   if (age_ff == nm1_ff) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_NORM;
         ST_NORM:  state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall    = 1'b1;
      out_load     = 1'b0;
      ctl.load     = 1'b0;
      ctl.add_prod = 1'b0;
      ctl.sel_norm = 1'b0;
      rd_age       = SLOT_W'(1);
      rd_comp      = comp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            ctl.load  = req_valid;
            rd_comp   = req_component;
         end
         ST_ACC: begin
            ctl.add_prod = (age_ff != '0);
            rd_age       = age_ff + SLOT_W'(1);
         end
         ST_DRAIN: ctl.add_prod = 1'b1;
         ST_NORM:  ctl.sel_norm = 1'b1;
         // keep the scaled product while the response register is held
         ST_OUT: begin
            out_load     = out_free;
            ctl.sel_norm = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      ctl.comp_ok  = comp_ok_ff;
      ctl.age      = age_ff;
      ctl.n        = n_ff;
      hist_wr_en   = accept && req_comp_ok;
      hist_wr_addr = {slot_ff, req_component};
      hist_rd_addr = {slot_ff - rd_age, rd_comp};
      comp_out     = comp_ff;
   end

   // counters and request context
   always_comb begin
      slot_in    = slot_ff;
      fill_in    = fill_ff;
      age_in     = age_ff;
      nm1_in     = nm1_ff;
      n_in       = n_ff;
      comp_in    = comp_ff;
      last_in    = last_ff;
      comp_ok_in = comp_ok_ff;
      if (accept) begin
         age_in     = '0;
         n_in       = n_calc;
         nm1_in     = SLOT_W'(n_calc - WIN_W'(1));
         comp_in    = req_component;
         last_in    = req_last_component;
         comp_ok_in = req_comp_ok;
      end
      if (state_ff == ST_ACC) begin
         age_in = age_ff + SLOT_W'(1);
      end
      if (out_load && last_ff) begin
         slot_in = slot_ff + SLOT_W'(1);
         if (fill_ff < WIN_W'(HIST_DEPTH)) begin
            fill_in = fill_ff + WIN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         fill_ff  <= fill_in;
      end
      age_ff     <= age_in;
      nm1_ff     <= nm1_in;
      n_ff       <= n_in;
      comp_ff    <= comp_in;
      last_ff    <= last_in;
      comp_ok_ff <= comp_ok_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= WIN_W'(HIST_DEPTH))
      else $error("fill count above history depth");

   a_age_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC |-> age_ff <= nm1_ff)
      else $error("age walked past window");

   a_accept_starts_walk: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_ACC && age_ff == '0)
      else $error("accepted request did not start the walk");

   a_slot_moves_on_done: assert property (@(posedge clock) disable iff (reset)
      slot_ff != $past(slot_ff) && !$past(reset) |-> $past(out_load) && $past(last_ff))
      else $error("ring slot moved without a finished last component");

endmodule
`default_nettype wire

/* dv/tb_windowed_decay_weighted_average_top.sv */
// self-checking testbench for the windowed decay-weighted average block
`timescale 1ns / 1ps
module tb_windowed_decay_weighted_average_top;
   import wdwa_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_AT     = 200;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_TAIL  = 40;
   localparam int PHASE_ITEMS = 66;
   localparam longint unsigned DECAY_Q32 = 64'd4085499269;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [COMP_W-1:0]       comp;
      logic                    last;
   } smooth_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [COMP_W-1:0]       comp;
   } smooth_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_wr_en;
   logic [WIN_W-1:0]        csr_wr_data;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [VAL_W-1:0] req_reward_value;
   logic [COMP_W-1:0]       req_component;
   logic                    req_last_component;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [VAL_W-1:0] rsp_smoothed_value;
   logic [COMP_W-1:0]       rsp_component_out;

   windowed_decay_weighted_average_top u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_reward_value   (req_reward_value),
      .req_component      (req_component),
      .req_last_component (req_last_component),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_smoothed_value (rsp_smoothed_value),
      .rsp_component_out  (rsp_component_out)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   smooth_req_type request_queue[$];
   smooth_rsp_type smoothed_due[$];
   smooth_req_type cur_req;
   smooth_rsp_type due;

   longint                  weight_tab[HIST_DEPTH];
   longint                  recip_tab[HIST_DEPTH+1];
   logic signed [VAL_W-1:0] hist_mem[MEM_DEPTH];
   int                      model_slot;
   int                      model_fill;
   int                      model_window;

   int   cycle_count    = 0;
   int   error_count    = 0;
   int   requests_sent  = 0;
   int   results_seen   = 0;
   int   windows_written = 0;
   int   send_gap       = 0;
   int   stall_left     = 0;
   int   hold_left      = 0;
   logic hold_done      = 1'b0;
   logic req_taken      = 1'b0;
   logic quiet          = 1'b0;

   function automatic int idle_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return VAL_W'(int'($urandom_range(0, 1023)) - 512);
         default: return VAL_W'($urandom);
      endcase
   endfunction

   function automatic smooth_rsp_type decay_average(smooth_req_type rq);
      smooth_rsp_type r;
      int          wl;
      int          n;
      int          a;
      int          slot;
      longint      acc;
      longint      y;
      wl = model_window;
      if (wl < 1) wl = 1;
      if (wl > HIST_DEPTH) wl = HIST_DEPTH;
      n = model_fill + 1;
      if (n > wl) n = wl;
      hist_mem[model_slot * MAX_COMPONENTS + int'(rq.comp)] = rq.value;
      acc = 0;
      for (a = 0; a < n; a++) begin
         slot = (model_slot + HIST_DEPTH - a) % HIST_DEPTH;
         acc += longint'(hist_mem[slot * MAX_COMPONENTS + int'(rq.comp)]) * weight_tab[a];
      end
      y = (acc * recip_tab[n] + (longint'(1) << 30)) >>> ROUND_SHIFT;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      r.value = y[VAL_W-1:0];
      r.comp  = rq.comp;
      if (rq.last) begin
         model_slot = (model_slot + 1) % HIST_DEPTH;
         if (model_fill < HIST_DEPTH) model_fill++;
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // request side
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_taken = 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (request_queue.size() > 0) begin
            cur_req = request_queue[0];
            request_queue.delete(0);
            req_reward_value   <= cur_req.value;
            req_component      <= cur_req.comp;
            req_last_component <= cur_req.last;
            req_valid          <= 1'b1;
            send_gap = idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (csr_wr_en) model_window = csr_wr_data;
         if (req_valid && !req_stall) begin
            smoothed_due.insert(smoothed_due.size(), decay_average(cur_req));
            req_taken = 1'b1;
            requests_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (smoothed_due.size() == 0) begin
               report_mismatch($sformatf("response with no request pending: value %0d comp %0d",
                                         rsp_smoothed_value, rsp_component_out));
            end else begin
               due = smoothed_due[0];
               smoothed_due.delete(0);
               if (rsp_smoothed_value !== due.value)
                  report_mismatch($sformatf("smoothed_value got %0d exp %0d (comp %0d)",
                                            rsp_smoothed_value, due.value, due.comp));
               if (rsp_component_out !== due.comp)
                  report_mismatch($sformatf("component_out got %0d exp %0d",
                                            rsp_component_out, due.comp));
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_windowed_decay_weighted_average_top: errors");
      $finish;
   end

   task automatic add_item(logic signed [VAL_W-1:0] v, int c, logic l);
      smooth_req_type rq;
      rq.value = v;
      rq.comp  = COMP_W'(c);
      rq.last  = l;
      request_queue.insert(request_queue.size(), rq);
   endtask

   task automatic add_vector(logic signed [VAL_W-1:0] v0, logic signed [VAL_W-1:0] v1,
                             logic signed [VAL_W-1:0] v2, logic signed [VAL_W-1:0] v3);
      add_item(v0, 0, 1'b0);
      add_item(v1, 1, 1'b0);
      add_item(v2, 2, 1'b0);
      add_item(v3, 3, 1'b1);
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
         #1;
      end while (request_queue.size() != 0 || req_valid || smoothed_due.size() != 0);
   endtask

   task automatic set_window(int w);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= WIN_W'(w);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      windows_written++;
   endtask

   initial begin
      longint unsigned q;
      longint unsigned total;
      int              a;
      int              p;
      int              made;
      int              phase_win[7];

      phase_win          = '{2, 31, 0, 15, -1, 1, -1};
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_valid          = 1'b0;
      req_reward_value   = '0;
      req_component      = '0;
      req_last_component = 1'b0;
      rsp_stall          = 1'b0;

      q = 64'd1 << 32;
      total = 0;
      recip_tab[0] = 0;
      for (a = 0; a < HIST_DEPTH; a++) begin
         weight_tab[a] = longint'((q + (64'd1 << 16)) >> 17);
         total += q;
         recip_tab[a+1] = longint'(((64'd1 << 48) + total / 2) / total);
         q = (q * DECAY_Q32 + (64'd1 << 31)) >> 32;
      end
      for (a = 0; a < MEM_DEPTH; a++) hist_mem[a] = '0;
      model_slot   = 0;
      model_fill   = 0;
      model_window = int'(WIN_RESET);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // field extremes under the reset window, then zero, oversized and single-vector windows
      add_vector(16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1);
      add_vector(16'sh7FFF, 16'sh7FFF, 16'sd1, 16'sd256);
      add_vector(16'sh8000, 16'sh8000, -16'sd256, 16'sh0080);
      set_window(0);
      add_vector(16'sh8000, 16'sh7FFF, 16'sh5555, 16'shAAAA);
      set_window(31);
      add_vector(16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1);
      set_window(1);
      add_vector(16'sh7FFF, -16'sd1, 16'sh8000, 16'sd1);

      // complete vectors in every ring slot before any irregular order
      set_window(16);
      for (a = 0; a < HIST_DEPTH; a++)
         add_vector(rand_value(), rand_value(), rand_value(), rand_value());

      for (p = 0; p < 7; p++) begin
         set_window(phase_win[p] < 0 ? $urandom_range(0, 31) : phase_win[p]);
         quiet = p[0];
         made = 0;
         while (made < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
               add_vector(rand_value(), rand_value(), rand_value(), rand_value());
               made += 4;
            end else begin
               add_item(rand_value(), $urandom_range(0, 3), 1'($urandom_range(0, 1)));
               made++;
            end
         end
      end

      wait_idle();
      repeat (DRAIN_TAIL) @(posedge clock);
      $display("run covered %0d requests and %0d responses over %0d window settings",
               requests_sent, results_seen, windows_written + 1);
      $display("window extremes 0, 1, 16 and 31, a long response hold-off and idle drains");
      if (error_count == 0) begin
         $display("tb_windowed_decay_weighted_average_top: clean");
      end else begin
         $display("tb_windowed_decay_weighted_average_top: errors");
      end
      $finish;
   end

endmodule
